/* hw/rtl/client_role_table_macros.svh */
// Assertion macros used by the checker file of the client role table.
`ifndef CLIENT_ROLE_TABLE_MACROS_SVH
`define CLIENT_ROLE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/crt_pkg.sv */
package crt_pkg;

	localparam int EntriesDef = 8;
	localparam int EntriesMax = 64;
	localparam int IdxMaxW = $clog2(EntriesMax);
	localparam int AddrW = 48;
	localparam int RoleW = 8;
	localparam int SlotW = 3;

	typedef enum logic [1:0] {
		REQ_DISCOVER = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_KNOWN = 3'd0,
		ST_NEW = 3'd1,
		ST_REJECT = 3'd2,
		ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	// Lookup token that travels down the chain of cells.
	typedef struct packed {
		logic valid;
		logic hit;
		logic [IdxMaxW-1:0] hit_slot;
		logic [RoleW-1:0] hit_role;
		logic free_found;
		logic [IdxMaxW-1:0] free_slot;
	} tok_t;

	// Write and clear commands broadcast to every cell.
	typedef struct packed {
		logic clear;
		logic wr_en;
		logic [IdxMaxW-1:0] wr_slot;
		logic [AddrW-1:0] wr_addr;
		logic [RoleW-1:0] wr_role;
	} cell_cmd_t;

endpackage

/* hw/rtl/crt_cell.sv */
module crt_cell
	import crt_pkg::*;
#(
	parameter int Idx = 0
) (
	input logic clk,
	input logic arst_n,
	input logic [AddrW-1:0] key,
	input cell_cmd_t cmd,
	input tok_t tok_in,
	output tok_t tok_out
);

	logic valid_q;
	logic [AddrW-1:0] addr_q;
	logic [RoleW-1:0] role_q;
	logic match;
	logic sel;
	tok_t tok_nxt;
	tok_t tok_q;

	assign match = valid_q && (addr_q == key);
	assign sel = cmd.wr_en && (cmd.wr_slot == IdxMaxW'(Idx));

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && match) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.hit_slot = IdxMaxW'(Idx);
			tok_nxt.hit_role = role_q;
		end
		if (!tok_in.free_found && !valid_q) begin
			tok_nxt.free_found = 1'b1;
			tok_nxt.free_slot = IdxMaxW'(Idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (cmd.clear) begin
				valid_q <= 1'b0;
			end else if (sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			addr_q <= cmd.wr_addr;
			role_q <= cmd.wr_role;
		end
	end

	assign tok_out = tok_q;

endmodule

/* hw/rtl/client_role_table.sv */
// Channel    Valid       Stall       Payload
// request    req_valid   req_stall   req_type, client_addr, offered_role
// response   rsp_valid   rsp_stall   status, role_out, slot
//
// The result of a discover or query comes from the token that walks the chain of cells
// one cell per cycle; a clear does not use the chain and sets its result directly.
// One request is in flight at a time, and req_stall is high from a request transfer until
// its result enters the output register, so the next transfer can follow in the cycle after.
// An unused request type is taken and dropped without a result.
// Reset clears all valid bits at once and the table is usable in the first cycle after it.
module client_role_table
	import crt_pkg::*;
#(
	parameter int ENTRIES = EntriesDef
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [AddrW-1:0] client_addr,
	input logic [RoleW-1:0] offered_role,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [2:0] status,
	output logic [RoleW-1:0] role_out,
	output logic [SlotW-1:0] slot
);

	logic busy_q;
	logic start_q;
	logic done_q;
	req_t kind_q;
	logic [AddrW-1:0] addr_q;
	logic [RoleW-1:0] offer_q;
	tok_t res_q;
	tok_t chain [ENTRIES+1];
	cell_cmd_t cmd;
	logic take;
	logic take_live;
	logic take_clear;
	logic load;
	logic ins;
	logic clr;
	status_t st_nxt;
	logic [RoleW-1:0] role_nxt;
	logic [SlotW-1:0] slot_nxt;
	logic rsp_valid_q;
	status_t status_q;
	logic [RoleW-1:0] role_q;
	logic [SlotW-1:0] slot_q;

	assign req_stall = busy_q;
	assign take = req_valid && !busy_q;
	assign take_clear = take && (req_type == REQ_CLEAR);
	assign take_live = take && (req_type == REQ_CLEAR || req_type == REQ_DISCOVER ||
		req_type == REQ_QUERY);
	assign load = done_q && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		chain[0] = '0;
		chain[0].valid = start_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		crt_cell #(
			.Idx(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.key(addr_q),
			.cmd(cmd),
			.tok_in(chain[i]),
			.tok_out(chain[i+1])
		);
	end

	always_comb begin
		st_nxt = ST_KNOWN;
		role_nxt = '0;
		slot_nxt = '0;
		ins = 1'b0;
		clr = 1'b0;
		priority if (kind_q == REQ_CLEAR) begin
			st_nxt = ST_CLEARED;
			clr = load;
		end else if (res_q.hit) begin
			st_nxt = ST_KNOWN;
			role_nxt = res_q.hit_role;
			slot_nxt = res_q.hit_slot[SlotW-1:0];
		end else if (kind_q == REQ_QUERY) begin
			st_nxt = ST_NOTFOUND;
		end else if (offer_q == '0) begin
			st_nxt = ST_REJECT;
		end else if (!res_q.free_found) begin
			st_nxt = ST_FULL;
		end else begin
			st_nxt = ST_NEW;
			role_nxt = offer_q;
			slot_nxt = res_q.free_slot[SlotW-1:0];
			ins = load;
		end
	end

	always_comb begin
		cmd.clear = clr;
		cmd.wr_en = ins;
		cmd.wr_slot = res_q.free_slot;
		cmd.wr_addr = addr_q;
		cmd.wr_role = offer_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			start_q <= 1'b0;
			done_q <= 1'b0;
			kind_q <= REQ_DISCOVER;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= take_live && !take_clear;
			if (take_live) begin
				busy_q <= 1'b1;
				kind_q <= req_t'(req_type);
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (take_clear || chain[ENTRIES].valid) begin
				done_q <= 1'b1;
			end else if (load) begin
				done_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q <= client_addr;
			offer_q <= offered_role;
		end
		if (chain[ENTRIES].valid) begin
			res_q <= chain[ENTRIES];
		end
		if (load) begin
			status_q <= st_nxt;
			role_q <= role_nxt;
			slot_q <= slot_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign role_out = role_q;
	assign slot = slot_q;

endmodule

/* hw/rtl/crt_checker.sv */
`include "client_role_table_macros.svh"

module crt_checker
	import crt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic [1:0] req_type,
	input logic [AddrW-1:0] client_addr,
	input logic [RoleW-1:0] offered_role,
	input logic rsp_valid,
	input logic rsp_stall,
	input logic [2:0] status,
	input logic [RoleW-1:0] role_out,
	input logic [SlotW-1:0] slot
);

	`CRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(role_out) && $stable(slot), "response changed while stalled")
	`CRT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && req_type != 2'd3, req_stall, "request transfer did not make the table busy")
	`CRT_ASSERT_NEXT(a_drop_unused, req_valid && !req_stall && req_type == 2'd3, !req_stall, "unused request type made the table busy")
	`CRT_ASSERT_NOW(a_status_range, rsp_valid, status != 3'd6 && status != 3'd7, "response status out of range")
	`CRT_ASSERT_NOW(a_empty_result, rsp_valid && (status == ST_REJECT || status == ST_FULL || status == ST_NOTFOUND || status == ST_CLEARED), role_out == '0 && slot == '0, "result without a client carries a role or slot")

endmodule

bind client_role_table crt_checker u_crt_checker (.*);

/* tb/tb_client_role_table.sv */
`timescale 1ns / 1ps

module tb_client_role_table;
	import crt_pkg::*;

	localparam int ENTRIES = EntriesDef;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1925;
	localparam int POOL_SIZE = 12;
	localparam int ROUND_ITEMS = 150;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 10;

	typedef struct {
		logic [1:0] kind;
		logic [AddrW-1:0] addr;
		logic [RoleW-1:0] role;
		int unsigned gap;
		bit drain;
	} client_req_t;

	typedef struct packed {
		status_t st;
		logic [RoleW-1:0] role;
		logic [SlotW-1:0] slot;
	} role_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = 2'd0;
	logic [AddrW-1:0] client_addr = '0;
	logic [RoleW-1:0] offered_role = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [2:0] status;
	logic [RoleW-1:0] role_out;
	logic [SlotW-1:0] slot;

	client_req_t pending_reqs[$];
	role_result_t expected_results[$];

	logic tbl_valid [ENTRIES];
	logic [AddrW-1:0] tbl_addr [ENTRIES];
	logic [RoleW-1:0] tbl_role [ENTRIES];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	bit burst_mode = 1'b0;
	bit drain_next = 1'b0;

	client_role_table #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.client_addr(client_addr),
		.offered_role(offered_role),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.role_out(role_out),
		.slot(slot)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [AddrW-1:0] rand_addr();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		return wide[AddrW-1:0];
	endfunction

	function automatic logic [RoleW-1:0] rand_role();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return '0;
		end
		if (r < 20) begin
			return '1;
		end
		return RoleW'($urandom_range(0, 255));
	endfunction

	task automatic add_req(input logic [1:0] kind, input logic [AddrW-1:0] addr,
			input logic [RoleW-1:0] role);
		client_req_t item;
		item.kind = kind;
		item.addr = addr;
		item.role = role;
		item.gap = burst_mode ? 0 : pick_gap();
		item.drain = drain_next;
		drain_next = 1'b0;
		pending_reqs.push_back(item);
	endtask

	// Updates the table copy and returns whether the request yields a result.
	function automatic bit predict_lookup(input logic [1:0] kind, input logic [AddrW-1:0] addr,
			input logic [RoleW-1:0] offer, output role_result_t res);
		int hit;
		int free_idx;
		hit = -1;
		free_idx = -1;
		res.st = ST_CLEARED;
		res.role = '0;
		res.slot = '0;
		if (kind == REQ_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tbl_valid[i] = 1'b0;
			end
			return 1'b1;
		end
		if (kind == REQ_UNUSED) begin
			return 1'b0;
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_addr[i] == addr) begin
				hit = i;
			end
			if (!tbl_valid[i]) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			res.st = ST_KNOWN;
			res.role = tbl_role[hit];
			res.slot = SlotW'(hit);
		end else if (kind == REQ_QUERY) begin
			res.st = ST_NOTFOUND;
		end else if (offer == '0) begin
			res.st = ST_REJECT;
		end else if (free_idx < 0) begin
			res.st = ST_FULL;
		end else begin
			tbl_valid[free_idx] = 1'b1;
			tbl_addr[free_idx] = addr;
			tbl_role[free_idx] = offer;
			res.st = ST_NEW;
			res.role = offer;
			res.slot = SlotW'(free_idx);
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatch_count++;
		$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : request_driver
		client_req_t item;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_type <= REQ_DISCOVER;
			client_addr <= '0;
			offered_role <= '0;
			send_gap <= 0;
		end else if (!(req_valid && req_stall)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && (!pending_reqs[0].drain ||
					(!req_valid && expected_results.size() == 0))) begin
				item = pending_reqs.pop_front();
				req_type <= item.kind;
				client_addr <= item.addr;
				offered_role <= item.role;
				send_gap <= item.gap;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : response_staller
		int unsigned n;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			calm_left <= 0;
		end else if (calm_left > 0) begin
			calm_left <= calm_left - 1;
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 199) == 0) begin
			calm_left <= $urandom_range(100, 400);
			rsp_stall <= 1'b0;
		end else begin
			n = pick_gap();
			rsp_stall <= (n != 0);
			stall_left <= (n > 0) ? n - 1 : 0;
		end
	end

	always @(posedge clk) begin : transfer_monitor
		role_result_t want;
		role_result_t got;
		bit has_result;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting", 8'(status), 8'd0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st) begin
						report_mismatch("status", 8'(status), 8'(want.st));
					end
					if (role_out !== want.role) begin
						report_mismatch("role_out", role_out, want.role);
					end
					if (slot !== want.slot) begin
						report_mismatch("slot", 8'(slot), 8'(want.slot));
					end
				end
			end
			if (req_valid && !req_stall) begin
				has_result = predict_lookup(req_type, client_addr, offered_role, got);
				if (has_result) begin
					expected_results.push_back(got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [AddrW-1:0] pool [POOL_SIZE];
		logic [AddrW-1:0] addr;
		logic [1:0] kind;
		int unsigned r;
		int counted;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_addr[i] = '0;
			tbl_role[i] = '0;
		end

		// Fill the table, overflow it, then clear it.
		add_req(REQ_QUERY, '0, 8'h11);
		add_req(REQ_DISCOVER, '0, 8'h00);
		add_req(REQ_DISCOVER, '0, 8'hFF);
		add_req(REQ_DISCOVER, '0, 8'h07);
		add_req(REQ_QUERY, '0, 8'h00);
		add_req(REQ_DISCOVER, '1, 8'h01);
		for (int i = 2; i < ENTRIES; i++) begin
			add_req(REQ_DISCOVER, AddrW'(1) << (i * 6), (i % 2) ? 8'hAA : 8'h55);
		end
		add_req(REQ_DISCOVER, 48'h1234_5678_9ABC, 8'h03);
		add_req(REQ_DISCOVER, 48'h1234_5678_9ABD, 8'h00);
		add_req(REQ_DISCOVER, AddrW'(1) << ((ENTRIES - 1) * 6), 8'h42);
		add_req(REQ_UNUSED, '1, 8'hFF);
		add_req(REQ_QUERY, 48'h8000_0000_0000, 8'h00);
		add_req(REQ_CLEAR, '0, 8'h00);
		add_req(REQ_QUERY, '0, 8'h00);
		add_req(REQ_DISCOVER, '1, 8'h80);
		add_req(REQ_CLEAR, '1, 8'hFF);
		add_req(REQ_CLEAR, '0, 8'h00);
		add_req(REQ_UNUSED, '0, 8'h00);
		drain_next = 1'b1;

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < POOL_SIZE; i++) begin
				r = $urandom_range(0, 9);
				if (i > 0 && r < 3) begin
					pool[i] = pool[i - 1] ^ (AddrW'(1) << $urandom_range(0, AddrW - 1));
				end else if (r == 3) begin
					pool[i] = (r % 2) ? '1 : '0;
				end else begin
					pool[i] = rand_addr();
				end
			end
			for (int j = 0; j < ROUND_ITEMS && counted < RANDOM_ITEMS; j++) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					kind = REQ_CLEAR;
				end else if (r < 5) begin
					kind = REQ_UNUSED;
				end else if (r < 35) begin
					kind = REQ_QUERY;
				end else begin
					kind = REQ_DISCOVER;
				end
				if ($urandom_range(0, 99) < 85) begin
					addr = pool[$urandom_range(0, POOL_SIZE - 1)];
				end else begin
					addr = rand_addr();
				end
				if (counted == RANDOM_ITEMS / 2) begin
					drain_next = 1'b1;
				end
				add_req(kind, addr, rand_role());
				if (kind != REQ_UNUSED) begin
					counted++;
				end
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid) begin
			@(posedge clk);
		end
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
